[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL files of the key decoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_ALWAYS(lbl, !(cond), msg)

`endif

[rtl/core/tekd_pkg.sv]
// ----------------------------------------------------------------------------
// tekd_pkg
// Types and constants of the terminal escape key decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tekd_pkg;

  localparam logic [7:0] ESC_CHAR      = 8'h1B;
  localparam logic [7:0] CSI_BYTE      = 8'h5B;  // '['
  localparam logic [7:0] SS3_BYTE      = 8'h4F;  // 'O'
  localparam logic [7:0] CR_BYTE       = 8'h0D;
  localparam logic [7:0] LF_BYTE       = 8'h0A;
  localparam logic [7:0] BS_BYTE       = 8'h08;
  localparam logic [7:0] DEL_BYTE      = 8'h7F;
  localparam logic [7:0] TAB_BYTE      = 8'h09;
  localparam logic [7:0] ETX_BYTE      = 8'h03;
  localparam logic [7:0] SYN_BYTE      = 8'h16;
  localparam logic [7:0] FINAL_UP      = 8'h41;
  localparam logic [7:0] FINAL_DOWN    = 8'h42;
  localparam logic [7:0] FINAL_RIGHT   = 8'h43;
  localparam logic [7:0] FINAL_LEFT    = 8'h44;
  localparam logic [7:0] ARROW_UP      = 8'd128;
  localparam logic [7:0] ARROW_DOWN    = 8'd129;
  localparam logic [7:0] ARROW_LEFT    = 8'd130;
  localparam logic [7:0] ARROW_RIGHT   = 8'd131;

  localparam logic [7:0] TIMEOUT_RST   = 8'd3;
  localparam logic [7:0] MAX_PARAM_RST = 8'd16;

  // config register indexes
  localparam logic CFG_TIMEOUT   = 1'b0;
  localparam logic CFG_MAX_PARAM = 1'b1;

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    PH_NONE = 2'd0,
    PH_HELD = 2'd1,
    PH_SEQ  = 2'd2
  } tekd_phase_t;

  typedef struct packed {
    logic       command;   // 0 byte, 1 tick
    logic [7:0] rx_byte;
  } tekd_in_t;

  typedef struct packed {
    logic [7:0] key_code;
    logic       last;
  } tekd_out_t;

  typedef struct packed {
    logic [7:0] timeout_ticks;
    logic [7:0] max_param_bytes;
  } tekd_cfg_t;

  // key codes made by one beat, code0 first
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] code0;
    logic [7:0] code1;
  } tekd_res_t;

endpackage

[rtl/core/terminal_escape_key_decoder.sv]
// ----------------------------------------------------------------------------
// terminal_escape_key_decoder
// Serial console byte and tick stream to key codes (arrows, newline, etc.).
// ----------------------------------------------------------------------------
// One input beat is taken per clock unless the queue is short of room. A
// beat lands in an input register, is decoded against the escape state once
// the queue has room, and its key codes (zero, one or two) go into a
// four-entry result queue that drives out_data. The queue sends one code per
// clock while out_ready is high, so a beat that makes two codes (a held Esc
// released by an ordinary byte) needs two output transfers. Input is held
// off while the queue has fewer than two free entries. Configuration is
// written through cfg_we/cfg_addr/cfg_wdata with no wait.
`timescale 1ns / 1ps

module terminal_escape_key_decoder import tekd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  tekd_in_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output tekd_out_t  out_data,
  input  logic       cfg_we,
  input  logic       cfg_addr,
  input  logic [7:0] cfg_wdata
);

  tekd_cfg_t cfg_r;
  tekd_in_t  item_r;
  logic      item_vld_r;
  logic      room;
  logic      fire;
  tekd_res_t res;

  assign fire     = item_vld_r && room;
  assign in_ready = !item_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ticks   <= TIMEOUT_RST;
      cfg_r.max_param_bytes <= MAX_PARAM_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TIMEOUT:   cfg_r.timeout_ticks   <= cfg_wdata;
        CFG_MAX_PARAM: cfg_r.max_param_bytes <= cfg_wdata;
        default:       cfg_r <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_data;
    end
  end

  tekd_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  tekd_key_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[rtl/core/tekd_decode.sv]
// ----------------------------------------------------------------------------
// tekd_decode
// Escape and byte filter state machine: one beat per cycle while fire is high, up to two codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tekd_decode import tekd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  tekd_in_t  item,
  input  tekd_cfg_t cfg,
  output tekd_res_t res
);

  typedef struct packed {
    logic       emit;
    logic [7:0] code;
    logic       prev_cr;
  } plain_t;

  tekd_phase_t phase_r, phase_nxt;
  logic [7:0]  ticks_r, ticks_nxt;
  logic [7:0]  pcnt_r,  pcnt_nxt;
  logic        cr_r,    cr_nxt;
  plain_t      pb;
  logic        go_plain;
  logic [7:0]  b;

  // ordinary byte filter, Esc handled by the caller
  function automatic plain_t plain_fn(input logic [7:0] x, input logic prev_cr);
    plain_t p;
    p.emit    = 1'b0;
    p.code    = x;
    p.prev_cr = 1'b0;
    if (x == CR_BYTE) begin
      p.emit    = 1'b1;
      p.code    = LF_BYTE;
      p.prev_cr = 1'b1;
    end else if (x == LF_BYTE) begin
      p.emit = !prev_cr;   // CRLF collapses to one newline
    end else if (x == DEL_BYTE || x == BS_BYTE) begin
      p.emit = 1'b1;
      p.code = BS_BYTE;
    end else if (x == TAB_BYTE || x == ETX_BYTE || x == SYN_BYTE) begin
      p.emit = 1'b1;
    end else if (x inside {[8'h20:8'h7E]}) begin
      p.emit = 1'b1;
    end
    return p;
  endfunction

  assign b  = item.rx_byte;
  assign pb = plain_fn(b, cr_r);

  always_comb begin
    phase_nxt = phase_r;
    ticks_nxt = ticks_r;
    pcnt_nxt  = pcnt_r;
    cr_nxt    = cr_r;
    res       = '0;
    go_plain  = 1'b0;
    if (fire) begin
      if (item.command) begin
        if (phase_r == PH_HELD || phase_r == PH_SEQ) begin
          if (ticks_r != 8'd0) begin
            ticks_nxt = ticks_r - 8'd1;
          end
          // countdown was zero or just reached zero
          if (ticks_r <= 8'd1) begin
            if (phase_r == PH_HELD) begin
              res.cnt   = 2'd1;
              res.code0 = ESC_CHAR;
            end
            phase_nxt = PH_NONE;
            pcnt_nxt  = 8'd0;
          end
        end
      end else begin
        case (phase_r)
          PH_HELD: begin
            ticks_nxt = cfg.timeout_ticks;
            if (b == CSI_BYTE || b == SS3_BYTE) begin
              phase_nxt = PH_SEQ;
              pcnt_nxt  = 8'd0;
            end else begin
              res.cnt   = 2'd1;
              res.code0 = ESC_CHAR;
              if (b != ESC_CHAR) begin
                phase_nxt = PH_NONE;
                go_plain  = 1'b1;
              end
            end
          end
          PH_SEQ: begin
            ticks_nxt = cfg.timeout_ticks;
            if (b inside {[8'h40:8'h7E]}) begin
              phase_nxt = PH_NONE;
              case (b)
                FINAL_UP:    begin res.cnt = 2'd1; res.code0 = ARROW_UP;    end
                FINAL_DOWN:  begin res.cnt = 2'd1; res.code0 = ARROW_DOWN;  end
                FINAL_RIGHT: begin res.cnt = 2'd1; res.code0 = ARROW_RIGHT; end
                FINAL_LEFT:  begin res.cnt = 2'd1; res.code0 = ARROW_LEFT;  end
                default:     res.cnt = 2'd0;
              endcase
            end else if ((b inside {[8'h20:8'h3F]}) && pcnt_r < cfg.max_param_bytes) begin
              pcnt_nxt = pcnt_r + 8'd1;
            end else begin
              phase_nxt = PH_NONE;
              go_plain  = 1'b1;
            end
          end
          default: go_plain = 1'b1;
        endcase
        if (go_plain) begin
          if (b == ESC_CHAR) begin
            phase_nxt = PH_HELD;
            ticks_nxt = cfg.timeout_ticks;
            pcnt_nxt  = 8'd0;
            cr_nxt    = 1'b0;
          end else begin
            cr_nxt = pb.prev_cr;
            if (pb.emit) begin
              if (res.cnt == 2'd0) begin
                res.cnt   = 2'd1;
                res.code0 = pb.code;
              end else begin
                res.cnt   = 2'd2;
                res.code1 = pb.code;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NONE;
      ticks_r <= 8'd0;
      pcnt_r  <= 8'd0;
      cr_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      ticks_r <= ticks_nxt;
      pcnt_r  <= pcnt_nxt;
      cr_r    <= cr_nxt;
    end
  end

  // two codes only come from a held Esc released by an ordinary byte
  `ASSERT_ALWAYS(a_two_codes_esc, res.cnt == 2'd2 |-> res.code0 == ESC_CHAR, "Esc missing")
  `ASSERT_NEVER(a_tick_single, fire && item.command && res.cnt == 2'd2, "tick made two codes")
  `ASSERT_NEVER(a_idle_no_res, !fire && res.cnt != 2'd0, "codes without a beat")

endmodule

[rtl/core/tekd_key_fifo.sv]
// ----------------------------------------------------------------------------
// tekd_key_fifo
// Small result queue: takes up to two codes a cycle, hands out one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tekd_key_fifo import tekd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  tekd_res_t res,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output tekd_out_t out_data
);

  localparam int CNT_W = FIFO_PTR_W + 1;

  tekd_out_t             mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  pop;

  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  // a beat may add two entries
  assign room      = (count_r <= CNT_W'(FIFO_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(res.cnt);
    rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(pop);
    count_nxt  = count_r + CNT_W'(res.cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= '{key_code: res.code0, last: (res.cnt == 2'd1)};
    end
    if (res.cnt == 2'd2) begin
      mem_r[wr_ptr_r + FIFO_PTR_W'(1)] <= '{key_code: res.code1, last: 1'b1};
    end
  end

  `ASSERT_ALWAYS(a_cnt_bound, count_r <= CNT_W'(FIFO_DEPTH), "queue count past depth")
  `ASSERT_ALWAYS(a_no_overflow, (res.cnt != 2'd0) |-> room, "codes pushed without room")
  `ASSERT_ALWAYS(a_ptr_gap, (wr_ptr_r - rd_ptr_r) == FIFO_PTR_W'(count_r), "pointers disagree with count")

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the terminal escape key decoder: directed bytes,
// then random escape, CSI/SS3, newline and tick traffic under several
// register settings and handshake stall patterns, checked against an
// in-bench decoder model beat by beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench import tekd_pkg::*; ();

  localparam logic [7:0] PRINT_LO  = 8'h20;
  localparam logic [7:0] PRINT_HI  = 8'h7E;
  localparam logic [7:0] PARAM_LO  = 8'h20;
  localparam logic [7:0] PARAM_HI  = 8'h3F;
  localparam logic [7:0] FINAL_LO  = 8'h40;
  localparam logic [7:0] FINAL_HI  = 8'h7E;
  localparam int         N_PHASES  = 8;
  localparam int         PHASE_LEN = 200;
  localparam int         SETTLE    = 8;
  localparam int         MAX_PRINT = 20;

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  tekd_in_t   in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  tekd_out_t  out_data;
  logic       cfg_we    = 1'b0;
  logic       cfg_addr  = CFG_TIMEOUT;
  logic [7:0] cfg_wdata = '0;

  terminal_escape_key_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // decoder state mirrored in the bench
  logic [7:0]  tmo_ticks  = TIMEOUT_RST;
  logic [7:0]  max_params = MAX_PARAM_RST;
  tekd_phase_t esc_ph     = PH_NONE;
  logic [7:0]  ticks_left = '0;
  logic [7:0]  param_cnt  = '0;
  logic        prev_cr    = 1'b0;

  tekd_out_t key_buf[2];
  int        key_cnt;

  tekd_in_t  stim_q[$];
  tekd_out_t key_q[$];

  int err_cnt       = 0;
  int beats_sent    = 0;
  int keys_seen     = 0;
  int phase_items   = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    if (err_cnt < MAX_PRINT)
      $display("MISMATCH @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------- predictor
  function automatic void add_key(logic [7:0] code);
    if (key_cnt < 2) begin
      if (key_cnt > 0)
        key_buf[key_cnt-1].last = 1'b0;
      key_buf[key_cnt].key_code = code;
      key_buf[key_cnt].last     = 1'b1;
      key_cnt++;
    end
  endfunction

  function automatic void decode_plain(logic [7:0] b);
    if (b == ESC_CHAR) begin
      esc_ph     = PH_HELD;
      ticks_left = tmo_ticks;
      param_cnt  = '0;
      prev_cr    = 1'b0;
    end else if (b == CR_BYTE) begin
      prev_cr = 1'b1;
      add_key(LF_BYTE);
    end else if (b == LF_BYTE) begin
      // LF right after CR is swallowed
      if (!prev_cr)
        add_key(LF_BYTE);
      prev_cr = 1'b0;
    end else begin
      prev_cr = 1'b0;
      if (b == DEL_BYTE || b == BS_BYTE)
        add_key(BS_BYTE);
      else if (b == TAB_BYTE || b == ETX_BYTE || b == SYN_BYTE)
        add_key(b);
      else if (b >= PRINT_LO && b <= PRINT_HI)
        add_key(b);
    end
  endfunction

  function automatic void decode_beat(tekd_in_t beat);
    logic [7:0] b;
    b = beat.rx_byte;
    key_cnt = 0;
    if (beat.command) begin
      if (esc_ph == PH_HELD || esc_ph == PH_SEQ) begin
        if (ticks_left != 0)
          ticks_left--;
        if (ticks_left == 0) begin
          if (esc_ph == PH_HELD)
            add_key(ESC_CHAR);
          esc_ph    = PH_NONE;
          param_cnt = '0;
        end
      end
    end else begin
      case (esc_ph)
        PH_HELD: begin
          ticks_left = tmo_ticks;
          if (b == CSI_BYTE || b == SS3_BYTE) begin
            esc_ph    = PH_SEQ;
            param_cnt = '0;
          end else begin
            add_key(ESC_CHAR);
            if (b != ESC_CHAR) begin
              esc_ph = PH_NONE;
              decode_plain(b);
            end
          end
        end
        PH_SEQ: begin
          ticks_left = tmo_ticks;
          if (b >= FINAL_LO && b <= FINAL_HI) begin
            esc_ph = PH_NONE;
            case (b)
              FINAL_UP:    add_key(ARROW_UP);
              FINAL_DOWN:  add_key(ARROW_DOWN);
              FINAL_RIGHT: add_key(ARROW_RIGHT);
              FINAL_LEFT:  add_key(ARROW_LEFT);
              default: ;
            endcase
          end else if (b >= PARAM_LO && b <= PARAM_HI && param_cnt < max_params) begin
            param_cnt++;
          end else begin
            esc_ph = PH_NONE;
            decode_plain(b);
          end
        end
        default: decode_plain(b);
      endcase
    end
    for (int i = 0; i < key_cnt; i++)
      key_q.push_back(key_buf[i]);
  endfunction

  // ------------------------------------------------------------------- driver
  always @(posedge clk) begin : drive_p
    tekd_in_t nxt;
    logic     nv;
    if (rst_n) begin
      nv  = in_valid;
      nxt = in_data;
      if (in_valid && in_ready) begin
        decode_beat(in_data);
        beats_sent++;
        nv = 1'b0;
      end
      if (!nv && stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = stim_q.pop_front();
        nv  = 1'b1;
      end
      in_valid <= nv;
      in_data  <= nxt;
    end
  end

  // ------------------------------------------------------------------ monitor
  always @(posedge clk) begin : monitor_p
    tekd_out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        keys_seen++;
        if (key_q.size() == 0) begin
          report_mismatch($sformatf("unexpected key 0x%02h last=%0b",
                                    out_data.key_code, out_data.last));
        end else begin
          want = key_q.pop_front();
          if (out_data.key_code !== want.key_code)
            report_mismatch($sformatf("key_code 0x%02h, want 0x%02h",
                                      out_data.key_code, want.key_code));
          if (out_data.last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b (key 0x%02h)",
                                      out_data.last, want.last, want.key_code));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic push_byte(logic [7:0] b);
    tekd_in_t it;
    it.command = 1'b0;
    it.rx_byte = b;
    stim_q.push_back(it);
    phase_items++;
  endtask

  task automatic push_tick();
    tekd_in_t it;
    it.command = 1'b1;
    it.rx_byte = 8'($urandom_range(255));  // ignored by the block
    stim_q.push_back(it);
    phase_items++;
  endtask

  task automatic push_ticks(int n);
    repeat (n) push_tick();
  endtask

  task automatic push_param();
    push_byte(8'($urandom_range(PARAM_HI, PARAM_LO)));
  endtask

  // one burst of random traffic: escape sequences, held Esc, newlines, parameter runs, single bytes or ticks
  task automatic gen_burst();
    int kind;
    int n;
    int r;
    kind = $urandom_range(99);
    if (kind < 30) begin
      push_byte(ESC_CHAR);
      push_byte($urandom_range(1) ? CSI_BYTE : SS3_BYTE);
      n = $urandom_range(3);
      repeat (n) push_param();
      r = $urandom_range(9);
      if (r < 7)
        push_byte(8'(FINAL_UP + $urandom_range(3)));
      else if (r < 9)
        push_byte(8'($urandom_range(FINAL_HI, FINAL_LO)));
      else
        push_byte(8'($urandom_range(255)));
      if ($urandom_range(3) == 0)
        push_ticks($urandom_range(2));
    end else if (kind < 42) begin
      // held Esc or open sequence left to the countdown
      push_byte(ESC_CHAR);
      if ($urandom_range(1))
        push_byte($urandom_range(1) ? CSI_BYTE : SS3_BYTE);
      if ($urandom_range(1))
        push_param();
      if ($urandom_range(39) == 0 || (tmo_ticks <= 4 && $urandom_range(1)))
        n = int'(tmo_ticks) + 1;
      else
        n = $urandom_range(4);
      push_ticks(n);
    end else if (kind < 52) begin
      push_byte(ESC_CHAR);
      if ($urandom_range(1))
        push_byte(ESC_CHAR);
      push_byte(8'($urandom_range(255)));
    end else if (kind < 62) begin
      n = $urandom_range(4, 2);
      repeat (n) begin
        r = $urandom_range(2);
        push_byte(r == 0 ? CR_BYTE : (r == 1 ? LF_BYTE : 8'($urandom_range(PRINT_HI, PRINT_LO))));
      end
    end else if (kind < 70) begin
      // run up to the parameter limit (past it when the limit is under 24), then a trailing byte
      push_byte(ESC_CHAR);
      push_byte(CSI_BYTE);
      n = (max_params < 24) ? int'(max_params) + 1 : $urandom_range(24, 1);
      repeat (n) push_param();
      push_byte(8'($urandom_range(255)));
    end else if (kind < 86) begin
      push_byte(8'($urandom_range(255)));
    end else begin
      push_tick();
    end
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    if (idx == CFG_TIMEOUT)
      tmo_ticks = val;
    else
      max_params = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // sampled at the falling edge so the driver's updates have settled
  task automatic drain();
    do @(negedge clk);
    while (stim_q.size() != 0 || in_valid || key_q.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin : main_p
    logic [7:0] tmo_set[N_PHASES];
    logic [7:0] par_set[N_PHASES];
    tmo_set = '{8'd3, 8'd1, 8'd255, 8'd0, 8'($urandom_range(255, 1)), 8'd2,
                8'($urandom_range(8, 1)), 8'd255};
    par_set = '{8'd16, 8'd0, 8'd255, 8'd1, 8'($urandom_range(255)), 8'd3,
                8'($urandom_range(20)), 8'd0};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: byte classes, sequences, Esc handling, countdown
    push_byte(PRINT_LO);
    push_byte(PRINT_HI);
    push_byte(8'hFF);
    push_byte(CR_BYTE);
    push_byte(LF_BYTE);
    push_byte(LF_BYTE);
    push_byte(DEL_BYTE);
    push_byte(BS_BYTE);
    push_byte(TAB_BYTE);
    push_byte(ETX_BYTE);
    push_byte(SYN_BYTE);
    push_byte(ESC_CHAR);
    push_byte(CSI_BYTE);
    push_byte(8'h35);
    push_byte(FINAL_UP);
    push_byte(ESC_CHAR);
    push_byte(SS3_BYTE);
    push_byte(8'h5A);
    push_byte(ESC_CHAR);
    push_byte(ESC_CHAR);
    push_byte(8'h71);
    push_byte(ESC_CHAR);
    push_byte(CSI_BYTE);
    push_byte(8'h01);
    push_byte(ESC_CHAR);
    push_ticks(3);
    push_tick();
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(CFG_TIMEOUT, tmo_set[p]);
      write_reg(CFG_MAX_PARAM, par_set[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      phase_items = 0;
      while (phase_items < PHASE_LEN)
        gen_burst();
      drain();
    end

    if (key_q.size() != 0)
      report_mismatch($sformatf("%0d key codes never arrived", key_q.size()));
    $display("Sent %0d beats (directed plus %0d register/stall phases), checked %0d key codes",
             beats_sent, N_PHASES, keys_seen);
    if (err_cnt == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin : watchdog_p
    #4_000_000;
    $display("Timeout waiting for the decoder");
    $display("Mismatches found");
    $finish;
  end

endmodule
